// ----- rtl/spmq_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants of the stable priority message queue.
// Depends on nothing; imported by the top level and spmq_ctrl.
package spmq_pkg;

  // Field widths fixed by the stream format
  localparam int unsigned PRIO_W     = 8;
  localparam int unsigned TYPE_W     = 8;
  localparam int unsigned IN_PAY_W   = 32;
  localparam int unsigned OUT_PAY_W  = 32;
  localparam int unsigned OCC_W      = 5;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned IN_TDATA_W = 48;
  localparam int unsigned OUT_TDATA_W = 56;
  localparam int unsigned OUT_USED_W = PRIO_W + TYPE_W + OUT_PAY_W + OCC_W;
  localparam int unsigned OUT_PAD_W  = OUT_TDATA_W - OUT_USED_W;

  // Operation carried in s_axis_tuser
  typedef enum logic {
    KIND_PUSH = 1'b0,
    KIND_POP  = 1'b1
  } kind_e;

  // Completion code carried in m_axis_tuser
  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // One result transaction
  typedef struct packed {
    status_e                status;
    logic [PRIO_W-1:0]      prio;
    logic [TYPE_W-1:0]      mtype;
    logic [OUT_PAY_W-1:0]   payload;
    logic [OCC_W-1:0]       occupancy;
  } res_t;

endpackage

// ----- rtl/stable_priority_message_queue.sv -----
`timescale 1ns / 1ps
// Stable priority message queue, top level.
// Uses spmq_pkg, spmq_ctrl and spmq_store.
//
// Usage: each transaction on the s_axis channel is one request. tuser = 0
// pushes a message (priority, type, payload handle); tuser = 1 pops the head,
// the oldest message of the highest priority. Every request gives exactly one
// transaction on m_axis with a status code, the popped fields (zero for a
// push or an error) and the number of stored entries afterwards.
// Entries live in a synchronous memory addressed through a circular head
// pointer. A push walks backwards from the tail one entry per cycle, moving
// lower-priority entries down a slot, past every stored entry of lower
// priority (up to QUEUE_DEPTH - 1); the memory port, one read and one write
// per cycle, sets that pace. Rejected requests go straight to the done state
// without touching the memory.
// One request is in flight at a time; the result sits in an output register,
// so the next request is taken while m_axis is stalled, and its completion
// waits only until that register is free.
// Reset empties the queue at once; memory contents are never read before
// being written, so no clearing pass is needed.
module stable_priority_message_queue import spmq_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH  = 16,
  parameter int unsigned PAYLOAD_BITS = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // tdata: priority_req[7:0], type_code[15:8], payload[47:16]
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // tuser: kind[0]
  input  logic                   s_axis_tuser,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // tdata: out_priority[7:0], out_type[15:8], out_payload[47:16],
  //        occupancy[52:48], zero padding above
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  // tuser: status[1:0]
  output logic [STATUS_W-1:0]    m_axis_tuser
);

  localparam int unsigned IDX_W   = $clog2(QUEUE_DEPTH);
  localparam int unsigned ENTRY_W = PRIO_W + TYPE_W + PAYLOAD_BITS;

  logic               res_valid;
  logic               res_ready;
  res_t               res;
  logic               mem_we;
  logic [IDX_W-1:0]   mem_waddr;
  logic [ENTRY_W-1:0] mem_wdata;
  logic               mem_re;
  logic [IDX_W-1:0]   mem_raddr;
  logic [ENTRY_W-1:0] mem_rdata;
  logic               out_valid_q;
  res_t               out_q;

  spmq_ctrl #(
    .QUEUE_DEPTH  (QUEUE_DEPTH),
    .PAYLOAD_BITS (PAYLOAD_BITS),
    .IDX_W        (IDX_W),
    .ENTRY_W      (ENTRY_W)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (s_axis_tvalid),
    .item_ready_o (s_axis_tready),
    .item_kind_i  (kind_e'(s_axis_tuser)),
    .item_prio_i  (s_axis_tdata[PRIO_W-1:0]),
    .item_type_i  (s_axis_tdata[PRIO_W +: TYPE_W]),
    .item_pay_i   (s_axis_tdata[PRIO_W+TYPE_W +: IN_PAY_W]),
    .res_valid_o  (res_valid),
    .res_ready_i  (res_ready),
    .res_o        (res),
    .mem_we_o     (mem_we),
    .mem_waddr_o  (mem_waddr),
    .mem_wdata_o  (mem_wdata),
    .mem_re_o     (mem_re),
    .mem_raddr_o  (mem_raddr),
    .mem_rdata_i  (mem_rdata)
  );

  spmq_store #(
    .DEPTH  (QUEUE_DEPTH),
    .WIDTH  (ENTRY_W),
    .ADDR_W (IDX_W)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Output register: load a finished result when the slot is free
  assign res_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
      if (res_valid) begin
        out_q <= res;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_q.status;
  assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, out_q.occupancy, out_q.payload,
                          out_q.mtype, out_q.prio};

  // A taken request blocks the input until its result has moved to the output register
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request accepted while another is in flight");

  // An empty pop leaves an empty queue and zero fields
  a_empty_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == ST_EMPTY) |->
      (out_q.occupancy == '0) && (out_q.prio == '0) && (out_q.payload == '0))
    else $error("empty pop reports stored entries or data");

  // A dropped push reports a full queue
  a_full_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == ST_FULL) |->
      (out_q.occupancy == OCC_W'(QUEUE_DEPTH)) && (out_q.prio == '0))
    else $error("full status with wrong occupancy");

  // Nothing is shown on the output without a finished result behind it
  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(res_valid))
    else $error("output valid without a finished result");

endmodule

// ----- rtl/spmq_store.sv -----
`timescale 1ns / 1ps
// Entry memory of the message queue: one write port, one read port,
// read data registered. Standalone, no package use.
module spmq_store #(
  parameter int unsigned DEPTH  = 16,
  parameter int unsigned WIDTH  = 48,
  parameter int unsigned ADDR_W = 4
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/spmq_ctrl.sv -----
`timescale 1ns / 1ps
// Sequencer of the message queue: circular head pointer, sorted insert by a
// backward walk that shifts entries one slot per cycle. Uses spmq_pkg.
module spmq_ctrl import spmq_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH  = 16,
  parameter int unsigned PAYLOAD_BITS = 32,
  parameter int unsigned IDX_W        = 4,
  parameter int unsigned ENTRY_W      = 48
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // item side
  input  logic                item_valid_i,
  output logic                item_ready_o,
  input  kind_e               item_kind_i,
  input  logic [PRIO_W-1:0]   item_prio_i,
  input  logic [TYPE_W-1:0]   item_type_i,
  input  logic [IN_PAY_W-1:0] item_pay_i,
  // result side
  output logic                res_valid_o,
  input  logic                res_ready_i,
  output res_t                res_o,
  // memory port
  output logic                mem_we_o,
  output logic [IDX_W-1:0]    mem_waddr_o,
  output logic [ENTRY_W-1:0]  mem_wdata_o,
  output logic                mem_re_o,
  output logic [IDX_W-1:0]    mem_raddr_o,
  input  logic [ENTRY_W-1:0]  mem_rdata_i
);

  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_POP,
    S_SCAN,
    S_PLACE,
    S_DONE
  } state_e;

  state_e                  state_q, state_d;
  logic [IDX_W-1:0]        head_q, head_d;
  logic [CNT_W-1:0]        count_q, count_d;
  logic [IDX_W-1:0]        idx_q, idx_d;
  logic [PRIO_W-1:0]       prio_q, prio_d;
  logic [TYPE_W-1:0]       type_q, type_d;
  logic [PAYLOAD_BITS-1:0] pay_q, pay_d;
  status_e                 rst_q, rst_d;
  logic [PRIO_W-1:0]       rprio_q, rprio_d;
  logic [TYPE_W-1:0]       rtype_q, rtype_d;
  logic [PAYLOAD_BITS-1:0] rpay_q, rpay_d;

  logic [IN_PAY_W+PAYLOAD_BITS-1:0]  in_pay_ext;
  logic [OUT_PAY_W+PAYLOAD_BITS-1:0] out_pay_ext;
  logic [OCC_W+CNT_W-1:0]            occ_ext;
  logic [PRIO_W-1:0]                 rd_prio;
  logic [ENTRY_W-1:0]                new_word;

  // Logical slot to physical address, wrapping once at the depth
  function automatic logic [IDX_W-1:0] phys(input logic [IDX_W-1:0] base,
                                            input logic [IDX_W-1:0] off);
    logic [IDX_W:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= (IDX_W+1)'(QUEUE_DEPTH)) begin
      sum = sum - (IDX_W+1)'(QUEUE_DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

  assign in_pay_ext  = {{PAYLOAD_BITS{1'b0}}, item_pay_i};
  assign out_pay_ext = {{OUT_PAY_W{1'b0}}, rpay_q};
  assign occ_ext     = {{OCC_W{1'b0}}, count_q};
  assign rd_prio     = mem_rdata_i[ENTRY_W-1 -: PRIO_W];
  assign new_word    = {prio_q, type_q, pay_q};

  // Next-state and memory control
  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    count_d     = count_q;
    idx_d       = idx_q;
    prio_d      = prio_q;
    type_d      = type_q;
    pay_d       = pay_q;
    rst_d       = rst_q;
    rprio_d     = rprio_q;
    rtype_d     = rtype_q;
    rpay_d      = rpay_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = phys(head_q, idx_q);
    mem_wdata_o = mem_rdata_i;
    mem_re_o    = 1'b0;
    mem_raddr_o = head_q;

    unique case (state_q)
      S_IDLE: begin
        if (item_valid_i) begin
          prio_d  = item_prio_i;
          type_d  = item_type_i;
          pay_d   = in_pay_ext[PAYLOAD_BITS-1:0];
          rprio_d = '0;
          rtype_d = '0;
          rpay_d  = '0;
          rst_d   = ST_OK;
          if (item_kind_i == KIND_POP) begin
            if (count_q == '0) begin
              rst_d   = ST_EMPTY;
              state_d = S_DONE;
            end else begin
              mem_re_o    = 1'b1;
              mem_raddr_o = head_q;
              state_d     = S_POP;
            end
          end else if (count_q >= CNT_W'(QUEUE_DEPTH)) begin
            rst_d   = ST_FULL;
            state_d = S_DONE;
          end else begin
            idx_d = count_q[IDX_W-1:0];
            if (count_q == '0) begin
              state_d = S_PLACE;
            end else begin
              // fetch the current tail
              mem_re_o    = 1'b1;
              mem_raddr_o = phys(head_q, count_q[IDX_W-1:0] - IDX_W'(1));
              state_d     = S_SCAN;
            end
          end
        end
      end

      S_POP: begin
        rprio_d = mem_rdata_i[ENTRY_W-1 -: PRIO_W];
        rtype_d = mem_rdata_i[PAYLOAD_BITS +: TYPE_W];
        rpay_d  = mem_rdata_i[PAYLOAD_BITS-1:0];
        head_d  = phys(head_q, IDX_W'(1));
        count_d = count_q - CNT_W'(1);
        state_d = S_DONE;
      end

      S_SCAN: begin
        mem_we_o = 1'b1;
        if (rd_prio >= prio_q) begin
          // stop behind an entry of equal or higher priority
          mem_wdata_o = new_word;
          count_d     = count_q + CNT_W'(1);
          state_d     = S_DONE;
        end else begin
          // shift the lower entry down one slot and walk on
          idx_d = idx_q - IDX_W'(1);
          if (idx_q == IDX_W'(1)) begin
            state_d = S_PLACE;
          end else begin
            mem_re_o    = 1'b1;
            mem_raddr_o = phys(head_q, idx_q - IDX_W'(2));
          end
        end
      end

      S_PLACE: begin
        mem_we_o    = 1'b1;
        mem_wdata_o = new_word;
        count_d     = count_q + CNT_W'(1);
        state_d     = S_DONE;
      end

      S_DONE: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      head_q  <= '0;
      count_q <= '0;
      idx_q   <= '0;
      prio_q  <= '0;
      type_q  <= '0;
      pay_q   <= '0;
      rst_q   <= ST_OK;
      rprio_q <= '0;
      rtype_q <= '0;
      rpay_q  <= '0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      count_q <= count_d;
      idx_q   <= idx_d;
      prio_q  <= prio_d;
      type_q  <= type_d;
      pay_q   <= pay_d;
      rst_q   <= rst_d;
      rprio_q <= rprio_d;
      rtype_q <= rtype_d;
      rpay_q  <= rpay_d;
    end
  end

  assign item_ready_o      = (state_q == S_IDLE);
  assign res_valid_o       = (state_q == S_DONE);
  assign res_o.status      = rst_q;
  assign res_o.prio        = rprio_q;
  assign res_o.mtype       = rtype_q;
  assign res_o.payload     = out_pay_ext[OUT_PAY_W-1:0];
  assign res_o.occupancy   = occ_ext[OCC_W-1:0];

endmodule
